FILE: src/rfs_pkg.sv
// Shared types, constants and the CRC-8 byte update for the radio frame sealer.
package rfs_pkg;

  // CRC-8 polynomial, MSB first, no reflection
  localparam logic [7:0] CRC_POLY    = 8'h31;
  // Option codes placed after the head byte
  localparam logic [7:0] CODE_NO_ACK = 8'h03;
  localparam logic [7:0] CODE_ACK    = 8'h04;

  // Configuration register indexes
  localparam logic CFG_HEAD = 1'b0;
  localparam logic CFG_TAIL = 1'b1;

  // One classified payload request on its way from front to back
  typedef struct packed {
    logic       first;  // opens a frame: head and option code go out before it
    logic       last;   // closes a frame: sequence, CRC and tail follow it
    logic       func;   // frame kind, meaningful on the first byte only
    logic [7:0] data;   // payload byte
  } rfs_entry_t;

  // Fold one byte into the running CRC
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/rfs_front.sv
// Front end: accepts payload requests, tracks the frame position and tags first and last bytes.
module rfs_front #(
  parameter int PAYLOAD_BYTES = 27
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [7:0]         in_data,
  output logic               push,
  output rfs_pkg::rfs_entry_t push_entry,
  input  logic               queue_full
);

  localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES - 1);

  logic [POS_W-1:0] pos;
  logic             at_first;
  logic             at_last;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign at_first = (pos == '0);
  assign at_last  = (pos == POS_LAST);

  // Classify the incoming byte
  always_comb begin
    push_entry.first = at_first;
    push_entry.last  = at_last;
    push_entry.func  = in_func;
    push_entry.data  = in_data;
  end

  // Advance the position, wrap after the last payload byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      if (at_last) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

endmodule

FILE: src/rfs_queue.sv
// Two-entry queue that decouples the front end from the frame emitter.
module rfs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rfs_pkg::rfs_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                avail,
  output rfs_pkg::rfs_entry_t pop_entry
);

  rfs_pkg::rfs_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign avail     = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: src/rfs_back.sv
// Back end: walks each queued request through its frame bytes, keeps CRC and sequence number.
module rfs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          head_byte,
  input  logic [7:0]          tail_byte,
  input  logic                avail,
  input  rfs_pkg::rfs_entry_t pop_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_end
);

  localparam logic [2:0] PH_HEAD = 3'd0;
  localparam logic [2:0] PH_CODE = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_SEQ  = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_TAIL = 3'd5;

  rfs_pkg::rfs_entry_t cur;
  logic       cur_valid;
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [7:0] crc;
  logic [7:0] crc_next;
  logic [7:0] seq;
  logic [7:0] byte_sel;
  logic       emit;
  logic       finishing;

  assign emit      = cur_valid && (!out_valid || out_ready);
  assign finishing = ((phase == PH_DATA) && !cur.last) || (phase == PH_TAIL);
  assign pop       = avail && (!cur_valid || (emit && finishing));

  // Select the byte for the current phase and the phase after it
  always_comb begin
    byte_sel   = cur.data;
    phase_next = phase;
    unique case (phase)
      PH_HEAD: begin
        byte_sel   = head_byte;
        phase_next = PH_CODE;
      end
      PH_CODE: begin
        byte_sel   = cur.func ? rfs_pkg::CODE_ACK : rfs_pkg::CODE_NO_ACK;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_sel   = cur.data;
        phase_next = PH_SEQ;
      end
      PH_SEQ: begin
        byte_sel   = seq;
        phase_next = PH_CRC;
      end
      PH_CRC: begin
        byte_sel   = crc;
        phase_next = PH_TAIL;
      end
      PH_TAIL: begin
        byte_sel   = tail_byte;
        phase_next = PH_TAIL;
      end
      default: begin
        byte_sel   = cur.data;
        phase_next = PH_DATA;
      end
    endcase
  end

  // Fold covered bytes into the CRC; the head byte restarts it
  always_comb begin
    crc_next = crc;
    if (phase == PH_HEAD) begin
      crc_next = rfs_pkg::crc8_byte(8'h00, byte_sel);
    end else if ((phase == PH_CODE) || (phase == PH_DATA) || (phase == PH_SEQ)) begin
      crc_next = rfs_pkg::crc8_byte(crc, byte_sel);
    end
  end

  // Load the next request or advance through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= PH_DATA;
      crc       <= 8'h00;
      seq       <= 8'h00;
    end else begin
      if (emit) begin
        crc <= crc_next;
        if (phase == PH_SEQ) begin
          seq <= seq + 8'd1;
        end
      end
      if (pop) begin
        cur_valid <= 1'b1;
        phase     <= pop_entry.first ? PH_HEAD : PH_DATA;
      end else if (emit) begin
        if (finishing) begin
          cur_valid <= 1'b0;
        end else begin
          phase <= phase_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_entry;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_sel;
      out_end  <= (phase == PH_TAIL);
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("pop from an empty queue");

  a_head_only_first: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && (phase == PH_HEAD || phase == PH_CODE)) |-> cur.first)
    else $error("frame header on a byte that does not open a frame");

  a_tail_marks_end: assert property (@(posedge clk) disable iff (rst)
    (emit && phase == PH_TAIL) |=> (out_valid && out_end))
    else $error("tail byte without end mark");

  a_seq_steps: assert property (@(posedge clk) disable iff (rst)
    (emit && phase == PH_SEQ) |=> (seq == 8'($past(seq) + 8'd1)))
    else $error("sequence number did not advance after a frame");

  a_trailer_only_last: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && (phase == PH_SEQ || phase == PH_CRC || phase == PH_TAIL)) |-> cur.last)
    else $error("frame trailer on a byte that does not close a frame");

endmodule

FILE: src/radio_frame_sealer_crc8.sv
// Top level of the radio frame sealer: configuration registers and the front, queue and back.
//
// Packs a stream of payload bytes into frames of PAYLOAD_BYTES + 5 bytes:
// head byte, option code (0x03 no-ack, 0x04 ack), payload, sequence number,
// CRC-8 (poly 0x31, init 0, MSB first, over head through sequence), tail.
// Input channel s_axis: tdata is the payload byte, tuser the frame kind,
// read on the first byte of each frame only. Output channel m_axis: tdata is
// the frame byte, tlast marks the tail byte.
// Configuration: cfg_we writes cfg_data into head byte (index 0) or tail
// byte (index 1); write only while no frame byte is in flight.
// An accepted request passes through a queue slot, the back end's request register
// and the output register before its first byte appears. The back end emits one
// frame byte per cycle while a request is queued and the receiver accepts; the input
// stalls only when the two-entry queue between front and back is full.
// Reset clears the frame position, CRC, sequence number and both registers.
// When the receiver stalls, the output register holds its byte, the back end
// stops, the queue fills and s_axis_tready drops.
module radio_frame_sealer_crc8 #(
  parameter int PAYLOAD_BYTES = 27
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
  input  logic       s_axis_tuser,   // [0] func
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] frame_byte
  output logic       m_axis_tlast,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] head_byte;
  logic [7:0] tail_byte;

  logic                push;
  rfs_pkg::rfs_entry_t push_entry;
  logic                queue_full;
  logic                pop;
  logic                avail;
  rfs_pkg::rfs_entry_t pop_entry;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= 8'h00;
      tail_byte <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfs_pkg::CFG_HEAD: head_byte <= cfg_data;
        rfs_pkg::CFG_TAIL: tail_byte <= cfg_data;
        default: head_byte <= head_byte;
      endcase
    end
  end

  rfs_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .push      (push),
    .push_entry(push_entry),
    .queue_full(queue_full)
  );

  rfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .pop       (pop),
    .avail     (avail),
    .pop_entry (pop_entry)
  );

  rfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_byte(head_byte),
    .tail_byte(tail_byte),
    .avail    (avail),
    .pop_entry(pop_entry),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_byte (m_axis_tdata),
    .out_end  (m_axis_tlast)
  );

endmodule
